[src/sip_pkg.sv]
// Shared types, constants and state encodings for the infection pressure block.
`timescale 1ns / 1ps
package sip_pkg;

  localparam int MAX_INFECTED_DEF = 256;
  localparam int COORD_W = 24;
  localparam int CFG_W = 24;
  localparam int COUNT_W = 16;
  localparam int TERM_W = 25;
  localparam int SUM_W = 32;
  localparam int PROB_W = 16;
  localparam int EXP_W = 33;
  localparam int ARG_W = 22;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [ARG_W-1:0] CLAMP_Q16 = 22'h200000;
  localparam logic [EXP_W-1:0] ONE_Q32 = 33'h1_0000_0000;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_EVAL  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SCALE     = 2'd0,
    REG_WEIGHT    = 2'd1,
    REG_INTERCEPT = 2'd2,
    REG_SLOPE     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]        scale;
    logic [CFG_W-1:0]        weight;
    logic signed [CFG_W-1:0] intercept;
    logic signed [CFG_W-1:0] slope;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [ARG_W-1:0] t;
  } exp_req_t;

  typedef enum logic [2:0] {
    E_IDLE, E_NDIV, E_MUL, E_KDIV, E_FIN
  } exp_state_t;

  typedef enum logic [3:0] {
    T_IDLE, T_SQ, T_SUM, T_ROOT, T_MUL, T_ARG, T_EXP, T_DIV, T_SCALE, T_DONE
  } term_state_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_START, S_TERM, S_FINAL, S_FWAIT, S_POST
  } top_state_t;

endpackage

[src/sip_if.sv]
// Valid/ready channels for command beats and result beats.
`timescale 1ns / 1ps
interface sip_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [23:0] x_position;
  logic [23:0] y_position;
  logic [15:0] infected_count;

  modport source (output valid, command, x_position, y_position, infected_count,
                  input ready);
  modport sink (input valid, command, x_position, y_position, infected_count,
                output ready);
endinterface

interface sip_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] infection_probability;
  logic [31:0] force_sum;
  logic        table_overflowed;

  modport source (output valid, infection_probability, force_sum, table_overflowed,
                  input ready);
  modport sink (input valid, infection_probability, force_sum, table_overflowed,
                output ready);
endinterface

[src/sip_expneg.sv]
// Iterative exp(-t) unit: range reduction by ln2, then a twelve-term Horner series.
`timescale 1ns / 1ps
module sip_expneg
  import sip_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  exp_req_t         req,
  output logic             done,
  output logic [EXP_W-1:0] e
);

  exp_state_t state, state_next;

  logic [37:0] rem;
  logic [5:0]  n;
  logic [2:0]  ncnt;
  logic [32:0] v;
  logic [3:0]  k;
  logic [31:0] dvd;
  logic [31:0] quo;
  logic [3:0]  krem;
  logic [1:0]  kcnt;

  logic [37:0] lsh;
  logic [63:0] prod;
  logic [3:0]  kr_c;
  logic [31:0] dvd_c;
  logic [31:0] quo_c;
  logic [4:0]  r5;
  logic [ARG_W-1:0] tcl;

  assign tcl  = (req.t > CLAMP_Q16) ? CLAMP_Q16 : req.t;
  assign lsh  = 38'(LN2_Q32) << ncnt;
  assign prod = 64'(rem[31:0]) * 64'(v);

  // eight restoring steps by the small Horner divisor
  always_comb begin
    kr_c  = krem;
    dvd_c = dvd;
    quo_c = quo;
    r5    = '0;
    for (int i = 0; i < 8; i++) begin
      r5    = {kr_c, dvd_c[31]};
      dvd_c = {dvd_c[30:0], 1'b0};
      if (r5 >= {1'b0, k}) begin
        r5    = r5 - {1'b0, k};
        quo_c = {quo_c[30:0], 1'b1};
      end else begin
        quo_c = {quo_c[30:0], 1'b0};
      end
      kr_c = r5[3:0];
    end
  end

  always_comb begin
    state_next = state;
    done = 1'b0;
    e = v >> n;
    case (state)
      E_IDLE: if (req.start) state_next = E_NDIV;
      E_NDIV: if (ncnt == 3'd0) state_next = E_MUL;
      E_MUL:  state_next = E_KDIV;
      E_KDIV: begin
        if (kcnt == 2'd3) state_next = (k == 4'd1) ? E_FIN : E_MUL;
      end
      E_FIN: begin
        done = 1'b1;
        state_next = E_IDLE;
      end
      default: state_next = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= E_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      E_IDLE: begin
        rem  <= {tcl, 16'b0};
        n    <= '0;
        ncnt <= 3'd5;
        v    <= ONE_Q32;
        k    <= 4'd12;
      end
      E_NDIV: begin
        if (rem >= lsh) begin
          rem     <= rem - lsh;
          n[ncnt] <= 1'b1;
        end
        ncnt <= ncnt - 3'd1;
      end
      E_MUL: begin
        dvd  <= prod[63:32];
        quo  <= '0;
        krem <= '0;
        kcnt <= '0;
      end
      E_KDIV: begin
        dvd  <= dvd_c;
        quo  <= quo_c;
        krem <= kr_c;
        kcnt <= kcnt + 2'd1;
        if (kcnt == 2'd3) begin
          v <= ONE_Q32 - {1'b0, quo_c};
          k <= k - 4'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

[src/sip_term.sv]
// Contribution of one stored position: distance, logistic kernel and scaling.
`timescale 1ns / 1ps
module sip_term
  import sip_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COORD_W-1:0] cx,
  input  logic [COORD_W-1:0] cy,
  input  logic [COORD_W-1:0] sx,
  input  logic [COORD_W-1:0] sy,
  input  cfg_t               cfg,
  input  logic               exp_done,
  input  logic [EXP_W-1:0]   exp_e,
  output exp_req_t           exp_req,
  output logic               done,
  output logic [TERM_W-1:0]  value
);

  term_state_t state, state_next;

  logic [COORD_W-1:0] dx, dy;
  logic [47:0] sqx, sqy;
  logic [50:0] sv, res, sbit;
  logic [37:0] scp;
  logic        neg;
  logic [49:0] drem, dsh;
  logic [16:0] quo;
  logic [4:0]  dcnt;
  logic [TERM_W-1:0] val;

  logic [48:0] s_c;
  logic [51:0] rb;
  logic [CFG_W-1:0] smag;
  logic signed [39:0] z;
  logic [39:0] zmag;
  logic [ARG_W-1:0] tcl;
  logic [33:0] den;
  logic [49:0] num;
  logic [41:0] scprod;

  assign s_c  = {1'b0, sqx} + {1'b0, sqy};
  assign rb   = {1'b0, res} + {1'b0, sbit};
  assign smag = cfg.slope[CFG_W-1] ? CFG_W'(-cfg.slope) : CFG_W'(cfg.slope);
  assign z    = cfg.slope[CFG_W-1] ? (40'(cfg.intercept) - $signed({2'b0, scp}))
                                   : (40'(cfg.intercept) + $signed({2'b0, scp}));
  assign zmag = z[39] ? 40'(-z) : 40'(z);
  assign tcl  = (zmag > 40'(CLAMP_Q16)) ? CLAMP_Q16 : zmag[ARG_W-1:0];
  assign den  = 34'(ONE_Q32) + 34'(exp_e);
  assign num  = neg ? ({1'b0, exp_e, 16'b0} + 50'(den >> 1))
                    : ((50'(1) << 48) + 50'(den >> 1));
  assign scprod = 42'(cfg.scale) * 42'(quo) + 42'd32768;

  always_comb begin
    state_next = state;
    exp_req.start = 1'b0;
    exp_req.t = tcl;
    done = 1'b0;
    value = val;
    case (state)
      T_IDLE: if (start) state_next = T_SQ;
      T_SQ:   state_next = T_SUM;
      T_SUM:  state_next = (s_c == '0) ? T_DONE : T_ROOT;
      T_ROOT: if (sbit == 51'd1) state_next = T_MUL;
      T_MUL:  state_next = T_ARG;
      T_ARG: begin
        exp_req.start = 1'b1;
        state_next = T_EXP;
      end
      T_EXP:   if (exp_done) state_next = T_DIV;
      T_DIV:   if (dcnt == 5'd16) state_next = T_SCALE;
      T_SCALE: state_next = T_DONE;
      T_DONE: begin
        done = 1'b1;
        state_next = T_IDLE;
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= T_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      T_IDLE: begin
        dx <= (cx > sx) ? cx - sx : sx - cx;
        dy <= (cy > sy) ? cy - sy : sy - cy;
      end
      T_SQ: begin
        sqx <= 48'(dx) * 48'(dx);
        sqy <= 48'(dy) * 48'(dy);
      end
      T_SUM: begin
        val  <= TERM_W'(cfg.weight);
        sv   <= 51'(s_c);
        res  <= '0;
        sbit <= 51'(1) << 50;
      end
      T_ROOT: begin
        if ({1'b0, sv} >= rb) begin
          sv  <= sv - rb[50:0];
          res <= (res >> 1) + sbit;
        end else begin
          res <= res >> 1;
        end
        sbit <= sbit >> 2;
      end
      T_MUL: scp <= 38'((49'(smag) * 49'(res[24:0]) + 49'd2048) >> 12);
      T_ARG: neg <= z[39];
      T_EXP: begin
        if (exp_done) begin
          drem <= num;
          dsh  <= 50'(den) << 16;
          quo  <= '0;
          dcnt <= '0;
        end
      end
      T_DIV: begin
        if (drem >= dsh) begin
          drem <= drem - dsh;
          quo  <= {quo[15:0], 1'b1};
        end else begin
          quo  <= {quo[15:0], 1'b0};
        end
        dsh  <= dsh >> 1;
        dcnt <= dcnt + 5'd1;
      end
      T_SCALE: val <= scprod[40:16];
      default: ;
    endcase
  end

endmodule

[src/spatial_infection_pressure.sv]
// Top level: position table, command handling, accumulation and configuration port.
// Clear and load leave the block idle; the next command beat is taken the cycle after.
// Evaluate walks the N stored positions one after another (a position at the centroid
// skips the kernel) and then offers its result beat; the walk is paced by the shared
// iterative exp(-t) unit, the 26-step square root and the 17-step divider; the result beat
// leaves through an output register. Synchronous reset empties the table, clears the
// overflow flag and restores defaults.
module spatial_infection_pressure
  import sip_pkg::*;
#(
  parameter int MAX_INFECTED = MAX_INFECTED_DEF
) (
  input  logic        clk,
  input  logic        rst,
  sip_in_if.sink      request,
  sip_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(MAX_INFECTED + 1);
  localparam int AW = (MAX_INFECTED > 1) ? $clog2(MAX_INFECTED) : 1;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_INFECTED);

  top_state_t state, state_next;

  logic [2*COORD_W-1:0] mem [MAX_INFECTED];
  logic [2*COORD_W-1:0] rdata;

  cfg_t cfg;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic          overflow;
  logic [COORD_W-1:0] cx, cy;
  logic [SUM_W-1:0]   sum;
  logic [PROB_W-1:0]  prob;

  logic out_valid;
  logic [PROB_W-1:0] out_prob;
  logic [SUM_W-1:0]  out_sum;
  logic              out_ovf;

  logic accept, slot_free, term_start, term_done, exp_done;
  logic [TERM_W-1:0] term_val;
  logic [EXP_W-1:0]  exp_e;
  exp_req_t term_req, top_req, exp_req;
  logic [SUM_W:0]  sum_add;
  logic [33:0]     p34;
  logic [CW-1:0]   idx_inc;

  assign accept    = request.valid && request.ready;
  assign slot_free = !out_valid || result.ready;
  assign request.ready = (state == S_IDLE);
  assign term_start = (state == S_START);
  assign sum_add   = {1'b0, sum} + (SUM_W + 1)'(term_val);
  assign p34       = 34'(ONE_Q32) - 34'(exp_e) + 34'd32768;
  assign idx_inc   = idx + CW'(1);

  assign top_req.start = (state == S_FINAL);
  assign top_req.t = (sum > 32'(CLAMP_Q16)) ? CLAMP_Q16 : sum[ARG_W-1:0];
  assign exp_req = (state == S_FINAL || state == S_FWAIT) ? top_req : term_req;

  assign result.valid = out_valid;
  assign result.infection_probability = out_prob;
  assign result.force_sum = out_sum;
  assign result.table_overflowed = out_ovf;

  sip_term u_term (
    .clk, .rst,
    .start (term_start),
    .cx, .cy,
    .sx (rdata[2*COORD_W-1:COORD_W]),
    .sy (rdata[COORD_W-1:0]),
    .cfg,
    .exp_done,
    .exp_e,
    .exp_req (term_req),
    .done (term_done),
    .value (term_val)
  );

  sip_expneg u_exp (
    .clk, .rst,
    .req (exp_req),
    .done (exp_done),
    .e (exp_e)
  );

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_SCALE:     prdata = 32'(cfg.scale);
      REG_WEIGHT:    prdata = 32'(cfg.weight);
      REG_INTERCEPT: prdata = 32'(unsigned'(cfg.intercept));
      REG_SLOPE:     prdata = 32'(unsigned'(cfg.slope));
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale     <= 24'd65536;
      cfg.weight    <= 24'd65536;
      cfg.intercept <= '0;
      cfg.slope     <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_SCALE:     cfg.scale     <= pwdata[23:0];
        REG_WEIGHT:    cfg.weight    <= pwdata[23:0];
        REG_INTERCEPT: cfg.intercept <= signed'(pwdata[23:0]);
        REG_SLOPE:     cfg.slope     <= signed'(pwdata[23:0]);
        default: ;
      endcase
    end
  end

  // position table
  always_ff @(posedge clk) begin
    if (accept && cmd_t'(request.command) == CMD_LOAD && request.infected_count != '0
        && count != MAX_C)
      mem[count[AW-1:0]] <= {request.x_position, request.y_position};
    rdata <= mem[idx[AW-1:0]];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && cmd_t'(request.command) == CMD_EVAL)
          state_next = (count == '0) ? S_FINAL : S_READ;
      end
      S_READ:  state_next = S_START;
      S_START: state_next = S_TERM;
      S_TERM: begin
        if (term_done) state_next = (idx_inc == count) ? S_FINAL : S_READ;
      end
      S_FINAL: state_next = S_FWAIT;
      S_FWAIT: if (exp_done) state_next = S_POST;
      S_POST:  if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) out_valid <= 1'b0;
      if (accept) begin
        case (cmd_t'(request.command))
          CMD_CLEAR: begin
            count    <= '0;
            overflow <= 1'b0;
          end
          CMD_LOAD: begin
            if (request.infected_count != '0) begin
              if (count == MAX_C) overflow <= 1'b1;
              else count <= count + CW'(1);
            end
          end
          default: ;
        endcase
      end
      if (state == S_POST && slot_free) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd_t'(request.command) == CMD_EVAL) begin
      cx  <= request.x_position;
      cy  <= request.y_position;
      idx <= '0;
      sum <= '0;
    end
    if (state == S_TERM && term_done) begin
      sum <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
      idx <= idx_inc;
    end
    if (state == S_FWAIT && exp_done)
      prob <= p34[33] ? {PROB_W{1'b1}} : p34[31:16] | {PROB_W{p34[32]}};
    if (state == S_POST && slot_free) begin
      out_prob <= prob;
      out_sum  <= sum;
      out_ovf  <= overflow;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= MAX_C)
    else $error("table count above capacity");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (idx < count))
    else $error("walk reads past the filled table");

  a_empty_eval: assert property (@(posedge clk) disable iff (rst)
    (accept && request.command == CMD_EVAL && count == '0) |=> (state == S_FINAL))
    else $error("empty table evaluate did not skip the walk");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    $rose(overflow) |-> (count == MAX_C))
    else $error("overflow flagged with room in the table");

endmodule

[sim/tb_spatial_infection_pressure.sv]
// Self-checking testbench for the infection pressure block: random traffic, stalls, APB setup.
`timescale 1ns / 1ps
module tb_spatial_infection_pressure;
  import sip_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int IDLE_LIMIT = 250000;
  localparam int ITEM_GOAL = 1900;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam longint unsigned Q32_ONE = 64'h1_0000_0000;
  localparam longint unsigned LN2_FRAC = 64'd2977044472;
  localparam longint unsigned T_CLAMP = 64'd32 << 16;
  localparam longint unsigned SUM_CAP = 64'hFFFF_FFFF;

  typedef struct {
    logic [1:0]  command;
    logic [23:0] x;
    logic [23:0] y;
    logic [15:0] count;
  } beat_t;

  typedef struct {
    logic [15:0] prob;
    logic [31:0] force_total;
    logic        ovf;
  } pressure_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sip_in_if request ();
  sip_out_if result ();

  spatial_infection_pressure uut (
    .clk(clk), .rst(rst), .request(request), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  beat_t     pending_beats[$];
  pressure_t expected_pressure[$];

  // model state
  logic [23:0] pos_x[TABLE_DEPTH];
  logic [23:0] pos_y[TABLE_DEPTH];
  int unsigned pos_count = 0;
  bit          pos_overflow = 1'b0;
  longint unsigned m_scale = 65536, m_weight = 65536;
  longint signed   m_intercept = 0, m_slope = 0;

  int  fail_count = 0;
  int  item_total = 0;
  int  idle_cycles = 0;
  bit  in_taken = 1'b0;
  bit  calm = 1'b0;
  bit  long_hold_req = 1'b0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 50;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // exp(-t), t in Q.16, result in Q1.32
  function automatic longint unsigned decay_q32(longint unsigned t16);
    longint unsigned t32, n, r, v;
    v = Q32_ONE;
    if (t16 > T_CLAMP) t16 = T_CLAMP;
    t32 = t16 << 16;
    n = t32 / LN2_FRAC;
    r = t32 - n * LN2_FRAC;
    for (int k = 12; k >= 1; k--) v = Q32_ONE - ((r * v) >> 32) / k;
    if (n >= 64) return 0;
    return v >> n;
  endfunction

  function automatic longint unsigned sigmoid_q16(longint signed z);
    longint unsigned mag, e, den;
    mag = (z < 0) ? longint'(-z) : longint'(z);
    if (mag > T_CLAMP) mag = T_CLAMP;
    e = decay_q32(mag);
    den = Q32_ONE + e;
    if (z >= 0) return ((64'd1 << 48) + (den >> 1)) / den;
    return ((e << 16) + (den >> 1)) / den;
  endfunction

  function automatic longint unsigned pair_rate(logic [23:0] cx, logic [23:0] cy,
                                                logic [23:0] sx, logic [23:0] sy);
    longint unsigned dx, dy, s, d, smag, prod;
    longint signed z;
    dx = (cx > sx) ? longint'(cx - sx) : longint'(sx - cx);
    dy = (cy > sy) ? longint'(cy - sy) : longint'(sy - cy);
    s = dx * dx + dy * dy;
    if (s == 0) return m_weight;
    d = isqrt(s);
    smag = (m_slope < 0) ? longint'(-m_slope) : longint'(m_slope);
    prod = (smag * d + 2048) >> 12;
    z = (m_slope < 0) ? m_intercept - longint'(prod) : m_intercept + longint'(prod);
    return (m_scale * sigmoid_q16(z) + 32768) >> 16;
  endfunction

  task automatic apply_beat(beat_t b);
    longint unsigned total, p;
    pressure_t res;
    total = 0;
    case (b.command)
      CMD_CLEAR: begin
        pos_count = 0;
        pos_overflow = 1'b0;
      end
      CMD_LOAD: begin
        if (b.count != 0) begin
          if (pos_count < TABLE_DEPTH) begin
            pos_x[pos_count] = b.x;
            pos_y[pos_count] = b.y;
            pos_count++;
          end else begin
            pos_overflow = 1'b1;
          end
        end
      end
      CMD_EVAL: begin
        for (int i = 0; i < pos_count; i++) begin
          total += pair_rate(b.x, b.y, pos_x[i], pos_y[i]);
          if (total > SUM_CAP) total = SUM_CAP;
        end
        p = (Q32_ONE - decay_q32(total) + 32768) >> 16;
        if (p > 65535) p = 65535;
        res.prob = p[15:0];
        res.force_total = total[31:0];
        res.ovf = pos_overflow;
        expected_pressure.push_back(res);
      end
      default: ;
    endcase
  endtask

  // accept beats, predict, check results, watchdog
  always @(posedge clk) begin
    beat_t b;
    pressure_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= request.valid && request.ready;
      if (request.valid && request.ready) begin
        b.command = request.command;
        b.x = request.x_position;
        b.y = request.y_position;
        b.count = request.infected_count;
        apply_beat(b);
      end
      if (result.valid && result.ready) begin
        if (expected_pressure.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          want = expected_pressure.pop_front();
          if (result.infection_probability !== want.prob) begin
            $error("infection_probability: expected %0d, got %0d",
                   want.prob, result.infection_probability);
            fail_count++;
          end
          if (result.force_sum !== want.force_total) begin
            $error("force_sum: expected %0d, got %0d", want.force_total, result.force_sum);
            fail_count++;
          end
          if (result.table_overflowed !== want.ovf) begin
            $error("table_overflowed: expected %0d, got %0d", want.ovf,
                   result.table_overflowed);
            fail_count++;
          end
        end
      end
      if ((request.valid && request.ready) || (result.valid && result.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // command driver
  int send_gap = 0;
  always @(negedge clk) begin
    beat_t b;
    if (rst) begin
      request.valid <= 1'b0;
      request.command <= CMD_CLEAR;
      request.x_position <= '0;
      request.y_position <= '0;
      request.infected_count <= '0;
    end else if (!request.valid || in_taken) begin
      if (send_gap > 0 || pending_beats.size() == 0) begin
        if (send_gap > 0) send_gap--;
        request.valid <= 1'b0;
      end else begin
        b = pending_beats.pop_front();
        request.valid <= 1'b1;
        request.command <= b.command;
        request.x_position <= b.x;
        request.y_position <= b.y;
        request.infected_count <= b.count;
        if (!calm) begin
          case ($urandom_range(0, 99)) inside
            [0:64]: send_gap = 0;
            [65:94]: send_gap = $urandom_range(1, 4);
            default: send_gap = $urandom_range(15, 70);
          endcase
        end
      end
    end
  end

  // result receiver
  int hold_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result.ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 4000;
      result.ready <= 1'b0;
    end else if (calm) begin
      result.ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:69]: result.ready <= 1'b1;
        [70:94]: begin
          hold_left = $urandom_range(0, 3);
          result.ready <= 1'b0;
        end
        default: begin
          hold_left = $urandom_range(20, 90);
          result.ready <= 1'b0;
        end
      endcase
    end
  end

  task automatic push(logic [1:0] c, logic [23:0] x, logic [23:0] y, logic [15:0] n);
    beat_t b;
    b.command = c;
    b.x = x;
    b.y = y;
    b.count = n;
    pending_beats.push_back(b);
    item_total++;
  endtask

  task automatic drain();
    wait (pending_beats.size() == 0 && !request.valid);
    wait (expected_pressure.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [23:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(idx) << 2;
    pwdata <= {8'h00, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SCALE: m_scale = value;
      REG_WEIGHT: m_weight = value;
      REG_INTERCEPT: m_intercept = longint'(signed'(value));
      default: m_slope = longint'(signed'(value));
    endcase
  endtask

  task automatic set_regs(logic [23:0] s, logic [23:0] w, logic [23:0] i, logic [23:0] k);
    write_reg(REG_SCALE, s);
    write_reg(REG_WEIGHT, w);
    write_reg(REG_INTERCEPT, i);
    write_reg(REG_SLOPE, k);
  endtask

  function automatic logic [23:0] coord();
    if ($urandom_range(0, 2) == 0) return 24'($urandom());
    return 24'(32'h400000 + $urandom_range(0, 32'h00FFFF));
  endfunction

  function automatic logic [23:0] small_signed();
    return 24'($signed($urandom_range(0, 24'h060000)) - 32'sh30000);
  endfunction

  initial begin
    int phase, loads;
    logic [23:0] lx, ly;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: defaults, then extremes
    push(CMD_EVAL, 24'h000000, 24'h000000, 16'h0000);
    push(CMD_LOAD, 24'h000000, 24'h000000, 16'h0001);
    push(CMD_LOAD, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    push(CMD_LOAD, 24'h123456, 24'h654321, 16'h0000);
    push(CMD_SPARE, 24'hFFFFFF, 24'h000000, 16'hFFFF);
    push(CMD_EVAL, 24'h000000, 24'h000000, 16'h0000);
    push(CMD_EVAL, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    push(CMD_EVAL, 24'h001000, 24'h002000, 16'h0000);
    drain();
    set_regs(24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h800000);
    push(CMD_EVAL, 24'h000000, 24'h000000, 16'h0000);
    push(CMD_EVAL, 24'h800000, 24'h000000, 16'h0000);
    push(CMD_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    push(CMD_EVAL, 24'h000000, 24'h000000, 16'h0000);
    drain();
    set_regs(24'h000000, 24'h000000, 24'h800000, 24'h7FFFFF);
    push(CMD_LOAD, 24'h000100, 24'h000100, 16'h0002);
    push(CMD_EVAL, 24'h000100, 24'h000100, 16'h0000);
    push(CMD_EVAL, 24'h000000, 24'h000000, 16'h0000);
    drain();
    // full table, then dropped loads
    set_regs(24'h010000, 24'h008000, 24'hFF0000, 24'hFFF000);
    push(CMD_CLEAR, '0, '0, '0);
    for (int i = 0; i < TABLE_DEPTH + 3; i++) push(CMD_LOAD, coord(), coord(), 16'h0001);
    push(CMD_EVAL, 24'h400800, 24'h400800, 16'h0000);
    push(CMD_CLEAR, '0, '0, '0);
    push(CMD_EVAL, 24'h400800, 24'h400800, 16'h0000);
    drain();

    phase = 0;
    while (item_total < ITEM_GOAL) begin
      calm = (phase % 5 == 3);
      case (phase % 4)
        0: set_regs(24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()));
        1: set_regs(24'($urandom_range(0, 24'h040000)), 24'($urandom_range(0, 24'h040000)),
                    small_signed(), small_signed());
        2: set_regs(24'hFFFFFF, 24'h000000, small_signed(), 24'h800000);
        default: set_regs(24'h000000, 24'hFFFFFF, 24'h7FFFFF, small_signed());
      endcase
      if (phase == 2) long_hold_req = 1'b1;
      for (int seq = 0; seq < 25; seq++) begin
        if ($urandom_range(0, 9) != 0)
          push(CMD_CLEAR, 24'($urandom()), 24'($urandom()), 16'($urandom()));
        loads = ($urandom_range(0, 29) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 10);
        lx = coord();
        ly = coord();
        for (int i = 0; i < loads; i++) begin
          lx = coord();
          ly = coord();
          push(CMD_LOAD, lx, ly, ($urandom_range(0, 9) == 0) ? 16'h0000
                                                             : 16'($urandom_range(1, 65535)));
          if ($urandom_range(0, 19) == 0)
            push(CMD_SPARE, 24'($urandom()), 24'($urandom()), 16'($urandom()));
        end
        for (int e = $urandom_range(1, 3); e > 0; e--) begin
          if ($urandom_range(0, 3) == 0) push(CMD_EVAL, lx, ly, 16'($urandom()));
          else push(CMD_EVAL, coord(), coord(), 16'($urandom()));
        end
      end
      drain();
      phase++;
    end

    drain();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[spatial_infection_pressure.f]
src/sip_pkg.sv
src/sip_if.sv
src/sip_expneg.sv
src/sip_term.sv
src/spatial_infection_pressure.sv
sim/tb_spatial_infection_pressure.sv
